// File: src/etpq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package etpq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_PEEK   = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [15:0] time_key;
    logic        departure;
    logic [15:0] length;
  } entry_t;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [15:0] event_time;
    logic        event_is_departure;
    logic [15:0] event_length;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        head_valid;
    logic [15:0] head_time;
    logic        head_is_departure;
    logic [15:0] head_length;
  } rsp_t;

  typedef struct packed {
    logic do_insert;
    logic do_remove;
  } cell_ctl_t;

endpackage

`default_nettype wire

// File: src/etpq_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module etpq_cell (
  input  logic               clk,
  input  etpq_pkg::cell_ctl_t ctl,
  input  logic               occupied,
  input  etpq_pkg::entry_t   new_entry,
  input  etpq_pkg::entry_t   prev_entry,
  input  logic               prev_ahead,
  input  etpq_pkg::entry_t   next_entry,
  output etpq_pkg::entry_t   entry,
  output logic               ahead
);
  import etpq_pkg::*;

  // existing entry stays ahead of the new event
  assign ahead = occupied &&
                 ((entry.time_key < new_entry.time_key) ||
                  ((entry.time_key == new_entry.time_key) &&
                   (entry.departure < new_entry.departure)));

  always_ff @(posedge clk) begin
    if (ctl.do_insert) begin
      if (!ahead) begin
        entry <= prev_ahead ? new_entry : prev_entry;
      end
    end else if (ctl.do_remove) begin
      entry <= next_entry;
    end
  end

endmodule

`default_nettype wire

// File: src/event_time_priority_queue.sv
`timescale 1ns / 1ps
`default_nettype none

// Sorted event queue built as a row of QUEUE_DEPTH cells. On insert every
// cell compares its entry with the new event in parallel and either holds,
// takes the new event, or takes its left neighbor, so the row stays ordered
// by time, arrivals before departures, newest first among equals. Remove
// shifts the row left by one. A request's result appears the cycle after its
// acceptance, and a new request is taken every cycle unless that result
// is stalled. The head fields of the result are read straight from the
// first cell.
module event_time_priority_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_stall,
  input  etpq_pkg::req_t   req,
  output logic             rsp_valid,
  input  logic             rsp_stall,
  output etpq_pkg::rsp_t   rsp
);
  import etpq_pkg::*;

  logic [CNT_W-1:0] count;
  logic [1:0]       status;
  logic             accept;
  logic             full;
  logic             empty;
  cell_ctl_t        ctl;
  entry_t           new_entry;
  entry_t           cell_q [QUEUE_DEPTH];
  logic             cell_ahead [QUEUE_DEPTH];
  logic [1:0]       status_next;
  logic [CNT_W-1:0] count_next;

  assign req_stall = rsp_valid && rsp_stall;
  assign accept    = req_valid && !req_stall;
  assign full      = (count == CNT_W'(QUEUE_DEPTH));
  assign empty     = (count == '0);

  assign new_entry.time_key  = req.event_time;
  assign new_entry.departure = req.event_is_departure;
  assign new_entry.length    = req.event_length;

  assign ctl.do_insert = accept && (req.opcode == OP_INSERT) && !full;
  assign ctl.do_remove = accept && (req.opcode == OP_REMOVE) && !empty;

  always_comb begin
    count_next  = count;
    status_next = empty ? ST_EMPTY : ST_OK;
    unique case (req.opcode)
      OP_INSERT: begin
        status_next = full ? ST_FULL : ST_OK;
        if (!full) begin
          count_next = count + CNT_W'(1);
        end
      end
      OP_REMOVE: begin
        if (!empty) begin
          count_next = count - CNT_W'(1);
        end
      end
      default: ;
    endcase
  end

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    etpq_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .occupied   (CNT_W'(i) < count),
      .new_entry  (new_entry),
      .prev_entry ((i == 0) ? new_entry : cell_q[(i == 0) ? 0 : i - 1]),
      .prev_ahead ((i == 0) ? 1'b1 : cell_ahead[(i == 0) ? 0 : i - 1]),
      .next_entry ((i == QUEUE_DEPTH - 1) ? cell_q[i] :
                   cell_q[(i == QUEUE_DEPTH - 1) ? i : i + 1]),
      .entry      (cell_q[i]),
      .ahead      (cell_ahead[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp_valid <= 1'b0;
      status    <= ST_OK;
    end else begin
      if (accept) begin
        count     <= count_next;
        status    <= status_next;
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  assign rsp.status            = status;
  assign rsp.head_valid        = !empty;
  assign rsp.head_time         = empty ? 16'd0 : cell_q[0].time_key;
  assign rsp.head_is_departure = empty ? 1'b0 : cell_q[0].departure;
  assign rsp.head_length       = empty ? 16'd0 : cell_q[0].length;

endmodule

`default_nettype wire

// File: src/etpq_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module etpq_checker (
  input logic           clk,
  input logic           rst,
  input logic           req_valid,
  input logic           req_stall,
  input logic           rsp_valid,
  input logic           rsp_stall,
  input etpq_pkg::rsp_t rsp
);
  import etpq_pkg::*;

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("result changed while stalled");

  a_one_cycle: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> rsp_valid)
    else $error("no result the cycle after an accepted item");

  a_full_has_head: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status == ST_FULL |-> rsp.head_valid)
    else $error("full status without a head");

  a_empty_no_head: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status == ST_EMPTY |-> !rsp.head_valid)
    else $error("empty status with a head");

  a_zero_head: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.head_valid |->
      rsp.head_time == 16'd0 && rsp.head_length == 16'd0 && !rsp.head_is_departure)
    else $error("head fields not zero on empty queue");

endmodule

bind event_time_priority_queue etpq_checker u_etpq_checker (.*);

`default_nettype wire
